// ===== hdl/qsm3_pkg.sv =====
package qsm3_pkg;

  // Pivot rule held in the mode register.
  typedef enum logic {
    PIVOT_MEDIAN3 = 1'b0,
    PIVOT_FIRST   = 1'b1
  } pivot_mode_t;

endpackage

// ===== hdl/qsm3_ram.sv =====
module qsm3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/quicksort_median_of_three.sv =====
// Streaming sorter. Signed words arrive on the in_ channel, one word per
// cycle, and are stored until a word with in_tlast high is taken. Words that
// arrive once MAX_ELEMENTS are held are dropped; a dropped word marked last
// still starts the sort. in_tready then stays low while the held words are
// sorted in place by quicksort with Lomuto partitioning, and the sorted words
// leave on the out_ channel in ascending order, out_tlast on the final one.
// The pivot rule is set by cfg_wr_data on a cycle with cfg_wr_en high; the
// user must do so only while the block is idle, as the block itself does not
// enforce it. 0 takes the median of the first, middle and last word of a
// range, 1 takes its first word.
// The store read is registered, and one comparator is shared by the median
// pick and the partition scan. The next sorted word is read from the store
// only once the receiver has taken the one before; a stalled receiver simply
// holds the output register. in_tready rises again as soon as the last
// sorted word is in the output register.
// Reset clears the word count, the range stack and the mode register, and
// leaves the block ready to load.
module quicksort_median_of_three #(
  parameter int MAX_ELEMENTS = 64,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] in_tdata,   // value
  input  logic                                in_tlast,   // last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] out_tdata,  // sorted_value
  output logic                                out_tlast   // final_res
);

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int IDX_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W   = IDX_W + 1;
  localparam int STK_W   = 2 * IDX_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

  typedef enum logic [4:0] {
    S_LOAD, S_START, S_POP, S_POP_W,
    S_MED0, S_MED1, S_MED2, S_MED3, S_MED4, S_MED5, S_MED6,
    S_PIV0, S_PIV1, S_PIV2, S_PIV3,
    S_SCAN0, S_SCAN1, S_SCAN2, S_SCAN3,
    S_FIN0, S_FIN1, S_FIN2, S_FIN3,
    S_PUSH0, S_PUSH1, S_ORD, S_OLD
  } state_t;

  state_t                  state_r, state_nxt;
  qsm3_pkg::pivot_mode_t   pivot_mode_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        sp_r;
  logic [IDX_W-1:0]        lo_r, hi_r, mid_r, piv_r, j_r, st_r, k_r;
  logic [DATA_WIDTH-1:0]   val_a_r, val_b_r, val_c_r, pv_r, hold_r;
  logic                    gab_r, gac_r, gba_r;
  logic [DATA_WIDTH-1:0]   out_data_r;
  logic                    out_valid_r, out_last_r;

  logic                    in_hs, out_hs;
  logic [DATA_WIDTH-1:0]   in_value;
  logic [CNT_W-1:0]        sp_dec, count_dec;

  logic                    st_wr_en, st_rd_en;
  logic [IDX_W-1:0]        st_wr_addr, st_rd_addr;
  logic [DATA_WIDTH-1:0]   st_wr_data, st_rd_data;

  logic                    stk_wr_en, stk_rd_en;
  logic [IDX_W-1:0]        stk_wr_addr, stk_rd_addr;
  logic [STK_W-1:0]        stk_wr_data, stk_rd_data;
  logic [IDX_W-1:0]        stk_lo, stk_hi;
  logic [CNT_W-1:0]        mid_sum;

  logic [DATA_WIDTH-1:0]   cmp_a, cmp_b;
  logic                    cmp_gt;

  logic                    push_right, push_left;
  logic [CNT_W-1:0]        st_inc, lo_inc;
  logic [IDX_W-1:0]        st_dec;

  assign in_hs    = in_tvalid && in_tready;
  assign out_hs   = out_tvalid && out_tready;
  assign in_value = in_tdata[DATA_WIDTH-1:0];
  assign sp_dec    = sp_r - CNT_W'(1);
  assign count_dec = count_r - CNT_W'(1);

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);
  assign out_tlast  = out_last_r;

  assign stk_lo  = stk_rd_data[STK_W-1:IDX_W];
  assign stk_hi  = stk_rd_data[IDX_W-1:0];
  assign mid_sum = {1'b0, stk_lo} + {1'b0, stk_hi};

  assign st_inc = {1'b0, st_r} + CNT_W'(1);
  assign lo_inc = {1'b0, lo_r} + CNT_W'(1);
  assign st_dec = st_r - IDX_W'(1);
  // Empty and single-word sub-ranges are not pushed.
  assign push_right = (st_inc < {1'b0, hi_r}) && (sp_r < MAX_CNT);
  assign push_left  = (lo_inc < {1'b0, st_r}) && (sp_r < MAX_CNT);

  // The one comparator, shared by the median pick and the partition scan.
  always_comb begin
    cmp_a = val_a_r;
    cmp_b = val_b_r;
    case (state_r)
      S_MED4: begin
        cmp_a = val_a_r;
        cmp_b = val_c_r;
      end
      S_MED5: begin
        cmp_a = val_b_r;
        cmp_b = val_a_r;
      end
      S_MED6: begin
        cmp_a = val_b_r;
        cmp_b = val_c_r;
      end
      S_SCAN1: begin
        cmp_a = st_rd_data;
        cmp_b = pv_r;
      end
      default: begin
        cmp_a = val_a_r;
        cmp_b = val_b_r;
      end
    endcase
  end

  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  // Memory port control, one access per port and cycle.
  always_comb begin
    st_wr_en    = 1'b0;
    st_wr_addr  = j_r;
    st_wr_data  = st_rd_data;
    st_rd_en    = 1'b0;
    st_rd_addr  = j_r;
    stk_wr_en   = 1'b0;
    stk_wr_addr = sp_r[IDX_W-1:0];
    stk_wr_data = {lo_r, hi_r};
    stk_rd_en   = 1'b0;
    stk_rd_addr = sp_dec[IDX_W-1:0];
    case (state_r)
      S_LOAD: begin
        st_wr_en   = in_hs && (count_r < MAX_CNT);
        st_wr_addr = count_r[IDX_W-1:0];
        st_wr_data = in_value;
      end
      S_START: begin
        stk_wr_en   = (count_r > CNT_W'(1));
        stk_wr_addr = '0;
        stk_wr_data = {IDX_W'(0), count_dec[IDX_W-1:0]};
      end
      S_POP: begin
        stk_rd_en = (sp_r != '0);
      end
      S_MED0: begin
        st_rd_en   = 1'b1;
        st_rd_addr = lo_r;
      end
      S_MED1: begin
        st_rd_en   = 1'b1;
        st_rd_addr = mid_r;
      end
      S_MED2, S_PIV1, S_FIN1: begin
        st_rd_en   = 1'b1;
        st_rd_addr = hi_r;
      end
      S_PIV0: begin
        st_rd_en   = 1'b1;
        st_rd_addr = piv_r;
      end
      S_PIV2: begin
        st_wr_en   = 1'b1;
        st_wr_addr = piv_r;
        st_wr_data = st_rd_data;
      end
      S_PIV3: begin
        st_wr_en   = 1'b1;
        st_wr_addr = hi_r;
        st_wr_data = pv_r;
      end
      S_SCAN0: begin
        st_rd_en   = 1'b1;
        st_rd_addr = j_r;
      end
      S_SCAN1, S_FIN0: begin
        st_rd_en   = 1'b1;
        st_rd_addr = st_r;
      end
      S_SCAN2: begin
        st_wr_en   = 1'b1;
        st_wr_addr = j_r;
        st_wr_data = st_rd_data;
      end
      S_SCAN3: begin
        st_wr_en   = 1'b1;
        st_wr_addr = st_r;
        st_wr_data = hold_r;
      end
      S_FIN2: begin
        st_wr_en   = 1'b1;
        st_wr_addr = st_r;
        st_wr_data = st_rd_data;
      end
      S_FIN3: begin
        st_wr_en   = 1'b1;
        st_wr_addr = hi_r;
        st_wr_data = hold_r;
      end
      S_PUSH0: begin
        stk_wr_en   = push_right;
        stk_wr_data = {st_inc[IDX_W-1:0], hi_r};
      end
      S_PUSH1: begin
        stk_wr_en   = push_left;
        stk_wr_data = {lo_r, st_dec};
      end
      S_ORD: begin
        st_rd_en   = !out_valid_r;
        st_rd_addr = k_r;
      end
      default: begin
        st_wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  state_nxt = (in_hs && in_tlast) ? S_START : S_LOAD;
      S_START: state_nxt = S_POP;
      S_POP:   state_nxt = (sp_r == '0) ? S_ORD : S_POP_W;
      S_POP_W: state_nxt = (pivot_mode_r == qsm3_pkg::PIVOT_FIRST) ? S_PIV0 : S_MED0;
      S_MED0:  state_nxt = S_MED1;
      S_MED1:  state_nxt = S_MED2;
      S_MED2:  state_nxt = S_MED3;
      S_MED3:  state_nxt = S_MED4;
      S_MED4:  state_nxt = S_MED5;
      S_MED5:  state_nxt = S_MED6;
      S_MED6:  state_nxt = S_PIV0;
      S_PIV0:  state_nxt = S_PIV1;
      S_PIV1:  state_nxt = S_PIV2;
      S_PIV2:  state_nxt = S_PIV3;
      S_PIV3:  state_nxt = S_SCAN0;
      S_SCAN0: state_nxt = (j_r == hi_r) ? S_FIN0 : S_SCAN1;
      S_SCAN1: state_nxt = cmp_gt ? S_SCAN0 : S_SCAN2;
      S_SCAN2: state_nxt = S_SCAN3;
      S_SCAN3: state_nxt = S_SCAN0;
      S_FIN0:  state_nxt = S_FIN1;
      S_FIN1:  state_nxt = S_FIN2;
      S_FIN2:  state_nxt = S_FIN3;
      S_FIN3:  state_nxt = S_PUSH0;
      S_PUSH0: state_nxt = S_PUSH1;
      S_PUSH1: state_nxt = S_POP;
      S_ORD:   state_nxt = out_valid_r ? S_ORD : S_OLD;
      S_OLD:   state_nxt = ({1'b0, k_r} == count_dec) ? S_LOAD : S_ORD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      pivot_mode_r <= qsm3_pkg::PIVOT_MEDIAN3;
      count_r      <= '0;
      sp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        pivot_mode_r <= qsm3_pkg::pivot_mode_t'(cfg_wr_data);
      end
      if (out_hs) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_hs && (count_r < MAX_CNT)) begin
            count_r <= count_r + CNT_W'(1);
          end
        end
        S_START: begin
          sp_r <= (count_r > CNT_W'(1)) ? CNT_W'(1) : CNT_W'(0);
          k_r  <= '0;
        end
        S_POP: begin
          if (sp_r != '0) begin
            sp_r <= sp_dec;
          end
        end
        S_POP_W: begin
          lo_r  <= stk_lo;
          hi_r  <= stk_hi;
          mid_r <= mid_sum[CNT_W-1:1];
          piv_r <= stk_lo;
        end
        S_MED1: val_a_r <= st_rd_data;
        S_MED2: val_b_r <= st_rd_data;
        S_MED3: begin
          val_c_r <= st_rd_data;
          gab_r   <= cmp_gt;
        end
        S_MED4: gac_r <= cmp_gt;
        S_MED5: gba_r <= cmp_gt;
        S_MED6: begin
          // Median: the first word if it lies between the other two,
          // else the middle word if it does, else the last word.
          if (gab_r != gac_r) begin
            piv_r <= lo_r;
          end else if (gba_r != cmp_gt) begin
            piv_r <= mid_r;
          end else begin
            piv_r <= hi_r;
          end
        end
        S_PIV1: pv_r <= st_rd_data;
        S_PIV3: begin
          j_r  <= lo_r;
          st_r <= lo_r;
        end
        S_SCAN1: begin
          hold_r <= st_rd_data;
          if (cmp_gt) begin
            j_r <= j_r + IDX_W'(1);
          end
        end
        S_SCAN3: begin
          j_r  <= j_r + IDX_W'(1);
          st_r <= st_r + IDX_W'(1);
        end
        S_FIN1: hold_r <= st_rd_data;
        S_PUSH0: begin
          if (push_right) begin
            sp_r <= sp_r + CNT_W'(1);
          end
        end
        S_PUSH1: begin
          if (push_left) begin
            sp_r <= sp_r + CNT_W'(1);
          end
        end
        S_OLD: begin
          out_data_r  <= st_rd_data;
          out_valid_r <= 1'b1;
          out_last_r  <= ({1'b0, k_r} == count_dec);
          if ({1'b0, k_r} == count_dec) begin
            count_r <= '0;
          end else begin
            k_r <= k_r + IDX_W'(1);
          end
        end
        default: begin
          sp_r <= sp_r;
        end
      endcase
    end
  end

  qsm3_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  qsm3_ram #(
    .WIDTH (STK_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input accepted while a sort is pending");

  a_load_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_wr_en && (state_r == S_LOAD)) |-> (count_r < MAX_CNT))
    else $error("word stored beyond the store depth");

  a_stack_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    stk_wr_en |-> (sp_r < MAX_CNT))
    else $error("range pushed onto a full stack");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OLD))
    else $error("output word raised outside the output load step");

endmodule
